>>> sv/rmoa_pkg.sv
// shared types, constants and control codes for the region motion overlap alarm
package rmoa_pkg;

  // number of region slots held by the datapath
  localparam int MAX_REGIONS = 4;
  localparam int RI_W        = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  // field widths
  localparam int COORD_W   = 10;
  localparam int SEC_W     = 17;
  localparam int SENS_W    = 7;
  localparam int CNT_W     = 3;
  localparam int CTRL_W    = 2;
  localparam int SUM_W     = 26;
  localparam int REGION_W  = 63;
  localparam int HITS_W    = 4;

  // stream and configuration port widths
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 63;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 27;
  localparam int MUL_B_W = 11;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [SENS_W:0]   PERCENT  = 8'd100;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_CNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DN_CTRL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DAY_START  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DAY_STOP   = 3'd7;

  // day/night control codes
  localparam logic [CTRL_W-1:0] DN_OFF   = 2'd0;
  localparam logic [CTRL_W-1:0] DN_FLAG  = 2'd1;
  localparam logic [CTRL_W-1:0] DN_TIMED = 2'd2;

  // one packed region, x in the lowest bits
  typedef struct packed {
    logic [SENS_W-1:0] night_sens;
    logic [SENS_W-1:0] day_sens;
    logic [SENS_W-1:0] close_sens;
    logic [9:0]        h;
    logic [10:0]       w;
    logic [9:0]        y;
    logic [10:0]       x;
  } region_t;

  typedef enum logic [1:0] {
    SENS_CLOSE,
    SENS_DAY,
    SENS_NIGHT
  } sens_sel_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_OVL,
    MUL_AREA,
    MUL_THR,
    MUL_SUM
  } mul_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OVL_MUL,
    ST_OVL_ADD,
    ST_AREA_MUL,
    ST_THR_MUL,
    ST_SUM_MUL,
    ST_CMP,
    ST_OUT
  } state_t;

  // sequencer to datapath control
  typedef struct packed {
    logic            idle;
    mul_op_t         op;
    logic            ovl_add;
    logic            area_ld;
    logic            thr_ld;
    logic            hit_ld;
    logic            out_ld;
    logic [RI_W-1:0] ri;
  } ctrl_t;

endpackage

>>> sv/rmoa_mul.sv
// shared signed multiplier with registered product
module rmoa_mul
  import rmoa_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod
);

  // one product per cycle, registered before use
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

>>> sv/rmoa_ctrl.sv
// sequencer stepping the shared multiplier over the regions of one item
module rmoa_ctrl
  import rmoa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             rect_valid,
  input  logic             last_rect,
  input  logic [CNT_W-1:0] n_regions,
  input  logic             out_busy,
  output ctrl_t            ctrl
);

  state_t          state, state_next;
  logic [RI_W-1:0] ri, ri_next;
  logic            item_last, item_last_next;
  logic            ri_last;

  assign ri_last = ((CNT_W'(ri) + CNT_W'(1)) == n_regions);

  // state and region index registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ri        <= '0;
      item_last <= 1'b0;
    end else begin
      state     <= state_next;
      ri        <= ri_next;
      item_last <= item_last_next;
    end
  end

  // next state
  always_comb begin
    state_next     = state;
    ri_next        = ri;
    item_last_next = item_last;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          ri_next        = '0;
          item_last_next = last_rect;
          if (rect_valid && (n_regions != '0)) begin
            state_next = ST_OVL_MUL;
          end else if (last_rect) begin
            state_next = (n_regions != '0) ? ST_AREA_MUL : ST_OUT;
          end
        end
      end
      ST_OVL_MUL: state_next = ST_OVL_ADD;
      ST_OVL_ADD: begin
        if (ri_last) begin
          ri_next    = '0;
          state_next = item_last ? ST_AREA_MUL : ST_IDLE;
        end else begin
          ri_next    = ri + RI_W'(1);
          state_next = ST_OVL_MUL;
        end
      end
      ST_AREA_MUL: state_next = ST_THR_MUL;
      ST_THR_MUL:  state_next = ST_SUM_MUL;
      ST_SUM_MUL:  state_next = ST_CMP;
      ST_CMP: begin
        if (ri_last) begin
          state_next = ST_OUT;
        end else begin
          ri_next    = ri + RI_W'(1);
          state_next = ST_AREA_MUL;
        end
      end
      ST_OUT: begin
        if (!out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl         = '0;
    ctrl.op      = MUL_NONE;
    ctrl.ri      = ri;
    unique case (state)
      ST_IDLE:     ctrl.idle    = 1'b1;
      ST_OVL_MUL:  ctrl.op      = MUL_OVL;
      ST_OVL_ADD:  ctrl.ovl_add = 1'b1;
      ST_AREA_MUL: ctrl.op      = MUL_AREA;
      ST_THR_MUL: begin
        ctrl.op      = MUL_THR;
        ctrl.area_ld = 1'b1;
      end
      ST_SUM_MUL: begin
        ctrl.op     = MUL_SUM;
        ctrl.thr_ld = 1'b1;
      end
      ST_CMP:      ctrl.hit_ld  = 1'b1;
      ST_OUT:      ctrl.out_ld  = !out_busy;
      default:     ctrl.idle    = 1'b0;
    endcase
  end

endmodule

>>> sv/region_motion_overlap_alarm.sv
// Region motion overlap alarm: accumulates box/region overlap and flags regions per frame.
// Sequence: an item with no box and no frame end is taken while idle; a box adds, per region
// in use, one multiplier pass plus a saturating add; the frame end adds, per region, the area,
// threshold and scaled sum on the shared multiplier, then the compare, and then the output load.
// Throughput: one item at a time, paced by the single shared multiplier; ready only when idle.
// Reset clears configuration, accumulators, hit flags, sequencer and the output valid flag.
module region_motion_overlap_alarm
  import rmoa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, is_night, seconds_of_day
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // rect_valid
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tlast,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // alarm, region_hits
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  function automatic logic [COORD_W-1:0] min4(input logic [COORD_W-1:0] a, b, c, d);
    logic [COORD_W-1:0] m0, m1;
    m0 = (b < a) ? b : a;
    m1 = (d < c) ? d : c;
    return (m1 < m0) ? m1 : m0;
  endfunction

  function automatic logic [COORD_W-1:0] max4(input logic [COORD_W-1:0] a, b, c, d);
    logic [COORD_W-1:0] m0, m1;
    m0 = (b > a) ? b : a;
    m1 = (d > c) ? d : c;
    return (m1 > m0) ? m1 : m0;
  endfunction

  region_t            regions [MAX_REGIONS];
  logic [CNT_W-1:0]   region_count;
  logic [CTRL_W-1:0]  day_night_ctrl;
  logic [SEC_W-1:0]   day_start_sec;
  logic [SEC_W-1:0]   day_stop_sec;

  logic [SUM_W-1:0]   overlap_sum [MAX_REGIONS];
  logic [COORD_W-1:0] bx0, bx1, by0, by1;
  sens_sel_t          sens_sel, sens_sel_next;
  logic               area_nz;
  logic signed [PROD_W-1:0] thr;
  logic [MAX_REGIONS-1:0]   hits;

  logic               out_valid;
  logic [OUT_TDATA_W-1:0] out_data;

  ctrl_t              ctrl;
  logic               in_accept;
  logic               out_busy;
  logic [CNT_W-1:0]   n_regions;
  logic               is_night;
  logic [SEC_W-1:0]   secs;

  region_t            reg_cur;
  logic [SUM_W-1:0]   sum_cur;
  logic [11:0]        rx_end;
  logic [10:0]        ry_end;
  logic [10:0]        ox_lo;
  logic [COORD_W-1:0] ox_hi;
  logic [COORD_W-1:0] oy_lo, oy_hi;
  logic [COORD_W-1:0] ow, oh;
  logic [SENS_W-1:0]  sens;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [SUM_W:0]     sum_add;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = ctrl.idle;
  assign cfg_ready = 1'b1;
  assign out_busy  = out_valid && !m_axis_tready;
  assign n_regions = (region_count > CNT_W'(MAX_REGIONS)) ? CNT_W'(MAX_REGIONS) : region_count;
  assign is_night  = s_axis_tdata[8*COORD_W];
  assign secs      = s_axis_tdata[8*COORD_W+1 +: SEC_W];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_REGIONS; i++) begin
        regions[i] <= '0;
      end
      region_count   <= '0;
      day_night_ctrl <= '0;
      day_start_sec  <= '0;
      day_stop_sec   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      for (int i = 0; i < MAX_REGIONS; i++) begin
        if (cfg_index == (CFG_REGION_0 + CFG_IDX_W'(i))) begin
          regions[i] <= region_t'(cfg_data);
        end
      end
      unique case (cfg_index)
        CFG_REGION_CNT: region_count   <= cfg_data[CNT_W-1:0];
        CFG_DN_CTRL:    day_night_ctrl <= cfg_data[CTRL_W-1:0];
        CFG_DAY_START:  day_start_sec  <= cfg_data[SEC_W-1:0];
        CFG_DAY_STOP:   day_stop_sec   <= cfg_data[SEC_W-1:0];
        default:        ;
      endcase
    end
  end

  // sensitivity choice from the accepted item's time inputs
  always_comb begin
    priority if (day_night_ctrl == DN_OFF) begin
      sens_sel_next = SENS_CLOSE;
    end else if (day_night_ctrl == DN_FLAG) begin
      sens_sel_next = is_night ? SENS_NIGHT : SENS_DAY;
    end else if (day_night_ctrl == DN_TIMED) begin
      sens_sel_next = ((secs >= day_start_sec) && (secs <= day_stop_sec)) ?
                      SENS_DAY : SENS_NIGHT;
    end else begin
      sens_sel_next = SENS_NIGHT;
    end
  end

  // capture bounding box and sensitivity choice per transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      bx0 <= min4(s_axis_tdata[0 +: COORD_W], s_axis_tdata[2*COORD_W +: COORD_W],
                  s_axis_tdata[4*COORD_W +: COORD_W], s_axis_tdata[6*COORD_W +: COORD_W]);
      bx1 <= max4(s_axis_tdata[0 +: COORD_W], s_axis_tdata[2*COORD_W +: COORD_W],
                  s_axis_tdata[4*COORD_W +: COORD_W], s_axis_tdata[6*COORD_W +: COORD_W]);
      by0 <= min4(s_axis_tdata[COORD_W +: COORD_W], s_axis_tdata[3*COORD_W +: COORD_W],
                  s_axis_tdata[5*COORD_W +: COORD_W], s_axis_tdata[7*COORD_W +: COORD_W]);
      by1 <= max4(s_axis_tdata[COORD_W +: COORD_W], s_axis_tdata[3*COORD_W +: COORD_W],
                  s_axis_tdata[5*COORD_W +: COORD_W], s_axis_tdata[7*COORD_W +: COORD_W]);
      sens_sel <= sens_sel_next;
    end
  end

  // current region and its span overlap with the box
  assign reg_cur = regions[ctrl.ri];
  assign sum_cur = overlap_sum[ctrl.ri];
  assign rx_end  = 12'(reg_cur.x) + 12'(reg_cur.w);
  assign ry_end  = 11'(reg_cur.y) + 11'(reg_cur.h);
  assign ox_lo   = (reg_cur.x > 11'(bx0)) ? reg_cur.x : 11'(bx0);
  assign ox_hi   = (rx_end < 12'(bx1)) ? rx_end[COORD_W-1:0] : bx1;
  assign ow      = (ox_lo < 11'(ox_hi)) ? (ox_hi - ox_lo[COORD_W-1:0]) : '0;
  assign oy_lo   = (reg_cur.y > by0) ? reg_cur.y : by0;
  assign oy_hi   = (ry_end < 11'(by1)) ? ry_end[COORD_W-1:0] : by1;
  assign oh      = (oy_lo < oy_hi) ? (oy_hi - oy_lo) : '0;

  always_comb begin
    unique case (sens_sel)
      SENS_CLOSE: sens = reg_cur.close_sens;
      SENS_DAY:   sens = reg_cur.day_sens;
      default:    sens = reg_cur.night_sens;
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.op)
      MUL_OVL: begin
        mul_a = MUL_A_W'(ow);
        mul_b = MUL_B_W'(oh);
      end
      MUL_AREA: begin
        mul_a = MUL_A_W'(reg_cur.w);
        mul_b = MUL_B_W'(reg_cur.h);
      end
      MUL_THR: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = MUL_B_W'(PERCENT) - MUL_B_W'(sens);
      end
      MUL_SUM: begin
        mul_a = MUL_A_W'(sum_cur);
        mul_b = MUL_B_W'(PERCENT);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  rmoa_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign sum_add = {1'b0, sum_cur} + (SUM_W+1)'(prod[2*COORD_W-1:0]);

  // saturating accumulators, cleared when the frame result is loaded
  always_ff @(posedge clk) begin
    if (rst || ctrl.out_ld) begin
      for (int i = 0; i < MAX_REGIONS; i++) begin
        overlap_sum[i] <= '0;
      end
    end else if (ctrl.ovl_add) begin
      overlap_sum[ctrl.ri] <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    end
  end

  // threshold terms and per-region hit flags
  always_ff @(posedge clk) begin
    if (ctrl.area_ld) begin
      area_nz <= (prod != '0);
    end
    if (ctrl.thr_ld) begin
      thr <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.out_ld) begin
      hits <= '0;
    end else if (ctrl.hit_ld) begin
      hits[ctrl.ri] <= area_nz && (prod > thr);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_ld) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_ld) begin
      out_data <= {3'b000, HITS_W'(hits), |hits};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  rmoa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (in_accept),
    .rect_valid (s_axis_tuser),
    .last_rect  (s_axis_tlast),
    .n_regions  (n_regions),
    .out_busy   (out_busy),
    .ctrl       (ctrl)
  );

endmodule

>>> sv/rmoa_chk.sv
// port-level checks for the region motion overlap alarm, bound to the top level
module rmoa_chk
  import rmoa_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tlast,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // the alarm bit agrees with the hit mask
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] == (|m_axis_tdata[4:1])))
    else $error("alarm does not match region hits");

  // a frame end keeps the input side busy for the evaluation
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input accepted during frame evaluation");

  // no result straight out of reset
  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind region_motion_overlap_alarm rmoa_chk u_rmoa_chk (.*);
